/* src/bbd_pkg.sv */
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared types and constants of the bitmask blend detector: the pixel pair and
// result payloads, the classifier summary and the pixel-test thresholds.
// ----------------------------------------------------------------------------
package bbd_pkg;

  // Field widths
  localparam int CH_BITS      = 8;
  localparam int THR_BITS     = 27;
  localparam int OUT_SUM_BITS = 27;
  localparam int CNT_BITS     = 24;
  localparam int SUM_BITS     = 27;   // running sum width, 16..40
  localparam int RESID_SHIFT  = 3;    // keep the top five bits of a residue
  localparam int RESID_BITS   = CH_BITS - RESID_SHIFT;
  localparam int ADD_BITS     = RESID_BITS + 2;   // three residues summed
  localparam int WIDE_BITS    = (SUM_BITS > OUT_SUM_BITS) ? SUM_BITS : OUT_SUM_BITS;

  // Pixel tests
  localparam logic [CH_BITS-1:0] MASK_WHITE_MIN  = 8'hF0;
  localparam logic [CH_BITS-1:0] FRONT_BLACK_LIM = 8'h10;
  localparam logic [CH_BITS-1:0] TOP5_MASK       = 8'hF8;
  localparam logic [CH_BITS-1:0] ABSENT_MASK     = 8'hFF;  // missing mask is white
  localparam logic [CH_BITS-1:0] ABSENT_FRONT    = 8'h00;  // missing front is black

  // Limits and reset values
  localparam logic [SUM_BITS-1:0]     SUM_MAX     = {SUM_BITS{1'b1}};
  localparam logic [CNT_BITS-1:0]     CNT_MAX     = {CNT_BITS{1'b1}};
  localparam logic [OUT_SUM_BITS-1:0] OUT_SUM_MAX = {OUT_SUM_BITS{1'b1}};
  localparam logic [THR_BITS-1:0]     THR_RESET   = THR_BITS'(10000);

  // One input transfer: front pixel, mask pixel, flags
  typedef struct packed {
    logic [CH_BITS-1:0] front_red;
    logic [CH_BITS-1:0] front_green;
    logic [CH_BITS-1:0] front_blue;
    logic               front_present;
    logic [CH_BITS-1:0] mask_red;
    logic [CH_BITS-1:0] mask_green;
    logic [CH_BITS-1:0] mask_blue;
    logic               mask_present;
    logic               last_pixel;
  } pixel_pair_t;

  // One output transfer, once per image
  typedef struct packed {
    logic                    mask_required;
    logic [OUT_SUM_BITS-1:0] blend_sum;
    logic [CNT_BITS-1:0]     blend_pixels;
  } blend_result_t;

  // Classifier verdict for one pixel pair
  typedef struct packed {
    logic                counted;
    logic [ADD_BITS-1:0] add;
  } pixel_class_t;

endpackage

/* src/bitmask_blend_detector.sv */
// ----------------------------------------------------------------------------
// bitmask_blend_detector
// Decides from a stream of front/mask pixel pairs whether an image needs real
// alpha blending, reporting the saturated blend sum and blended pixel count.
// ----------------------------------------------------------------------------
// One pixel pair is taken per clock cycle unless the input stalls. A pair is
// registered on entry, then classified and accumulated as it leaves the input
// register; an image's result is loaded into the result register when its
// last pair leaves the input register. Pairs that are not last never wait on
// the result side; the input stalls only when a last pair is ready while the
// previous result is still held by a stalled consumer. The threshold port is
// always ready and should be written only while the block is idle.
module bitmask_blend_detector (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pixel_valid,
  output logic                          pixel_stall,
  input  bbd_pkg::pixel_pair_t          pixel,
  output logic                          result_valid,
  input  logic                          result_stall,
  output bbd_pkg::blend_result_t        result,
  input  logic                          threshold_valid,
  output logic                          threshold_ready,
  input  logic [bbd_pkg::THR_BITS-1:0]  threshold
);

  logic                  stage_valid;
  logic                  stage_valid_next;
  bbd_pkg::pixel_pair_t  stage;
  bbd_pkg::pixel_class_t verdict;
  logic                  advance;
  logic                  take;

  assign threshold_ready = 1'b1;

  // Input register: refills whenever its pair moves on or it is empty
  assign pixel_stall      = stage_valid && !advance;
  assign take             = pixel_valid && !pixel_stall;
  assign stage_valid_next = take || (stage_valid && !advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= stage_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage <= pixel;
    end
  end

  // Pixel tests
  bbd_classify u_classify (
    .pair    (stage),
    .verdict (verdict)
  );

  // Accumulate and report
  bbd_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (stage_valid),
    .item_last    (stage.last_pixel),
    .verdict      (verdict),
    .advance      (advance),
    .thr_write    (threshold_valid && threshold_ready),
    .thr_data     (threshold),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

/* src/bbd_classify.sv */
// ----------------------------------------------------------------------------
// bbd_classify
// Per-pixel tests: substitutes absent pixels, checks the near-white mask /
// near-black front and covered cases, and sums the three channel residues.
// ----------------------------------------------------------------------------
module bbd_classify (
  input  bbd_pkg::pixel_pair_t  pair,
  output bbd_pkg::pixel_class_t verdict
);

  logic [2:0][bbd_pkg::CH_BITS-1:0] front_raw;
  logic [2:0][bbd_pkg::CH_BITS-1:0] mask_raw;
  logic [2:0][bbd_pkg::CH_BITS-1:0] front;
  logic [2:0][bbd_pkg::CH_BITS-1:0] mask;
  logic [2:0][bbd_pkg::CH_BITS-1:0] resid;
  logic                             mask_white;
  logic                             front_black;
  logic                             covered;
  logic [bbd_pkg::ADD_BITS-1:0]     add;

  assign front_raw = {pair.front_red, pair.front_green, pair.front_blue};
  assign mask_raw  = {pair.mask_red, pair.mask_green, pair.mask_blue};

  // Channel tests and residue sum
  always_comb begin
    mask_white  = 1'b1;
    front_black = 1'b1;
    covered     = 1'b1;
    add         = '0;
    for (int c = 0; c < 3; c++) begin
      front[c] = pair.front_present ? front_raw[c] : bbd_pkg::ABSENT_FRONT;
      mask[c]  = pair.mask_present  ? mask_raw[c]  : bbd_pkg::ABSENT_MASK;
      resid[c] = mask[c] & ~front[c];
      if (mask[c] < bbd_pkg::MASK_WHITE_MIN) begin
        mask_white = 1'b0;
      end
      if (front[c] >= bbd_pkg::FRONT_BLACK_LIM) begin
        front_black = 1'b0;
      end
      if ((resid[c] & bbd_pkg::TOP5_MASK) != '0) begin
        covered = 1'b0;
      end
      add = add + bbd_pkg::ADD_BITS'(resid[c][bbd_pkg::CH_BITS-1:bbd_pkg::RESID_SHIFT]);
    end
  end

  assign verdict.counted = !(mask_white && front_black) && !covered;
  assign verdict.add     = add;

endmodule

/* src/bbd_accum.sv */
// ----------------------------------------------------------------------------
// bbd_accum
// Saturating sum and pixel count, threshold register, and the result
// register that closes an image on its last pixel.
// ----------------------------------------------------------------------------
module bbd_accum (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  logic                          item_last,
  input  bbd_pkg::pixel_class_t         verdict,
  output logic                          advance,
  input  logic                          thr_write,
  input  logic [bbd_pkg::THR_BITS-1:0]  thr_data,
  output logic                          result_valid,
  input  logic                          result_stall,
  output bbd_pkg::blend_result_t        result
);

  logic [bbd_pkg::SUM_BITS-1:0]  sum_acc;
  logic [bbd_pkg::SUM_BITS-1:0]  sum_acc_next;
  logic [bbd_pkg::CNT_BITS-1:0]  pixel_acc;
  logic [bbd_pkg::CNT_BITS-1:0]  pixel_acc_next;
  logic [bbd_pkg::THR_BITS-1:0]  threshold;
  logic                          result_valid_next;
  logic [bbd_pkg::SUM_BITS:0]    sum_raw;
  logic [bbd_pkg::SUM_BITS-1:0]  sum_new;
  logic [bbd_pkg::CNT_BITS-1:0]  pixel_new;
  logic [bbd_pkg::WIDE_BITS-1:0] sum_wide;
  logic                          load_result;

  // A pair moves on unless it closes an image and the result slot is held
  assign advance     = item_valid && (!item_last || !result_valid || !result_stall);
  assign load_result = advance && item_last;

  // Saturating updates
  assign sum_raw = {1'b0, sum_acc} + (bbd_pkg::SUM_BITS + 1)'(verdict.add);

  always_comb begin
    sum_new   = sum_acc;
    pixel_new = pixel_acc;
    if (verdict.counted) begin
      sum_new = sum_raw[bbd_pkg::SUM_BITS] ? bbd_pkg::SUM_MAX
                                           : sum_raw[bbd_pkg::SUM_BITS-1:0];
      if (pixel_acc != bbd_pkg::CNT_MAX) begin
        pixel_new = pixel_acc + 1'b1;
      end
    end
  end

  // Accumulators: updated per pair, cleared when an image closes
  always_comb begin
    sum_acc_next   = sum_acc;
    pixel_acc_next = pixel_acc;
    if (advance) begin
      sum_acc_next   = item_last ? '0 : sum_new;
      pixel_acc_next = item_last ? '0 : pixel_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_acc   <= '0;
      pixel_acc <= '0;
      threshold <= bbd_pkg::THR_RESET;
    end else begin
      sum_acc   <= sum_acc_next;
      pixel_acc <= pixel_acc_next;
      if (thr_write) begin
        threshold <= thr_data;
      end
    end
  end

  // Result register
  assign sum_wide          = bbd_pkg::WIDE_BITS'(sum_new);
  assign result_valid_next = load_result || (result_valid && result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result.mask_required <= sum_wide >= bbd_pkg::WIDE_BITS'(threshold);
      result.blend_sum     <= (sum_wide > bbd_pkg::WIDE_BITS'(bbd_pkg::OUT_SUM_MAX))
                              ? bbd_pkg::OUT_SUM_MAX
                              : sum_wide[bbd_pkg::OUT_SUM_BITS-1:0];
      result.blend_pixels  <= pixel_new;
    end
  end

`ifndef SYNTHESIS
  // A nonzero sum always comes with at least one counted pixel
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.blend_pixels != '0 || result.blend_sum == '0))
    else $error("bbd_accum: blend sum without counted pixels");

  // Reported requirement agrees with the threshold
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.mask_required) |->
      (bbd_pkg::WIDE_BITS'(result.blend_sum) >= bbd_pkg::WIDE_BITS'(threshold)))
    else $error("bbd_accum: mask_required below threshold");

  // A new result only follows a closing pair
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_valid && item_last))
    else $error("bbd_accum: result without a last pixel");

  // Closing an image clears both accumulators
  assert property (@(posedge clk) disable iff (rst)
    load_result |=> (sum_acc == '0 && pixel_acc == '0))
    else $error("bbd_accum: accumulators not cleared after last pixel");
`endif

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: bitmask blend detector
// Streams front/mask pixel pairs into the detector, predicts each image report
// from a local copy of the blend sum, pixel count and threshold, and checks
// every report field by field. Short directed images cover the skip rules,
// absent pixels and threshold edges; random phases follow with several
// threshold settings and different amounts of sender idling and result stalls.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Shapes of generated pixel pairs
  typedef enum int {
    PK_RANDOM,
    PK_SKIP_BW,
    PK_COVERED,
    PK_ONE_BIT,
    PK_DENSE,
    PK_CORNER
  } pair_kind_t;

  // Predicts image reports and holds the ones not yet seen
  class blend_tally_model;
    logic [bbd_pkg::THR_BITS-1:0] threshold_reg;
    logic [bbd_pkg::SUM_BITS-1:0] sum_acc;
    logic [bbd_pkg::CNT_BITS-1:0] pixel_acc;
    bbd_pkg::blend_result_t       expected_reports[$];
    int mismatches;
    int pairs_taken;
    int pairs_blended;
    int reports_seen;
    int required_seen;

    function new();
      threshold_reg = bbd_pkg::THR_RESET;
      sum_acc       = '0;
      pixel_acc     = '0;
      mismatches    = 0;
      pairs_taken   = 0;
      pairs_blended = 0;
      reports_seen  = 0;
      required_seen = 0;
    endfunction

    function void set_threshold(input logic [bbd_pkg::THR_BITS-1:0] value);
      threshold_reg = value;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    // Classify one accepted pair, accumulate, and queue a report on the last one
    function void take_pair(input bbd_pkg::pixel_pair_t p);
      logic [bbd_pkg::CH_BITS-1:0]  fch [3];
      logic [bbd_pkg::CH_BITS-1:0]  mch [3];
      logic [bbd_pkg::CH_BITS-1:0]  resid;
      logic [bbd_pkg::SUM_BITS:0]   widened;
      bit                           mask_white;
      bit                           front_black;
      bit                           covered;
      logic [bbd_pkg::ADD_BITS-1:0] add;
      bbd_pkg::blend_result_t       r;
      fch[0] = p.front_present ? p.front_red   : bbd_pkg::ABSENT_FRONT;
      fch[1] = p.front_present ? p.front_green : bbd_pkg::ABSENT_FRONT;
      fch[2] = p.front_present ? p.front_blue  : bbd_pkg::ABSENT_FRONT;
      mch[0] = p.mask_present  ? p.mask_red    : bbd_pkg::ABSENT_MASK;
      mch[1] = p.mask_present  ? p.mask_green  : bbd_pkg::ABSENT_MASK;
      mch[2] = p.mask_present  ? p.mask_blue   : bbd_pkg::ABSENT_MASK;
      mask_white  = 1'b1;
      front_black = 1'b1;
      covered     = 1'b1;
      add         = '0;
      for (int c = 0; c < 3; c++) begin
        resid = mch[c] & ~fch[c];
        if (mch[c] < bbd_pkg::MASK_WHITE_MIN) mask_white = 1'b0;
        if (fch[c] >= bbd_pkg::FRONT_BLACK_LIM) front_black = 1'b0;
        if ((resid & bbd_pkg::TOP5_MASK) != '0) covered = 1'b0;
        add = add + bbd_pkg::ADD_BITS'(resid >> bbd_pkg::RESID_SHIFT);
      end
      pairs_taken++;
      if (!(mask_white && front_black) && !covered) begin
        widened = {1'b0, sum_acc} + (bbd_pkg::SUM_BITS + 1)'(add);
        sum_acc = (widened > bbd_pkg::SUM_MAX) ? bbd_pkg::SUM_MAX
                                               : widened[bbd_pkg::SUM_BITS-1:0];
        if (pixel_acc != bbd_pkg::CNT_MAX) pixel_acc++;
        pairs_blended++;
      end
      if (p.last_pixel) begin
        r.mask_required = (sum_acc >= threshold_reg);
        r.blend_sum     = (sum_acc > bbd_pkg::OUT_SUM_MAX) ? bbd_pkg::OUT_SUM_MAX
                                                           : bbd_pkg::OUT_SUM_BITS'(sum_acc);
        r.blend_pixels  = pixel_acc;
        expected_reports.push_back(r);
        sum_acc   = '0;
        pixel_acc = '0;
      end
    endfunction

    // Compare one accepted report with the oldest prediction
    function void check_report(input bbd_pkg::blend_result_t got);
      bbd_pkg::blend_result_t want;
      if (expected_reports.size() == 0) begin
        $display("%0t: report with none expected: expected none, actual %p", $time, got);
        mismatches++;
        return;
      end
      want = expected_reports.pop_front();
      reports_seen++;
      if (got.mask_required === 1'b1) required_seen++;
      if (got.mask_required !== want.mask_required) begin
        $display("%0t: mask_required expected %0d, actual %0d",
                 $time, want.mask_required, got.mask_required);
        mismatches++;
      end
      if (got.blend_sum !== want.blend_sum) begin
        $display("%0t: blend_sum expected %0d, actual %0d",
                 $time, want.blend_sum, got.blend_sum);
        mismatches++;
      end
      if (got.blend_pixels !== want.blend_pixels) begin
        $display("%0t: blend_pixels expected %0d, actual %0d",
                 $time, want.blend_pixels, got.blend_pixels);
        mismatches++;
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst             = 1'b1;
  logic                         pixel_valid     = 1'b0;
  logic                         pixel_stall;
  bbd_pkg::pixel_pair_t         pixel           = '0;
  logic                         result_valid;
  logic                         result_stall    = 1'b0;
  bbd_pkg::blend_result_t       result;
  logic                         threshold_valid = 1'b0;
  logic                         threshold_ready;
  logic [bbd_pkg::THR_BITS-1:0] threshold       = '0;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int thr_writes    = 0;

  blend_tally_model tally = new();

  bitmask_blend_detector dut (
    .clk             (clk),
    .rst             (rst),
    .pixel_valid     (pixel_valid),
    .pixel_stall     (pixel_stall),
    .pixel           (pixel),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .result          (result),
    .threshold_valid (threshold_valid),
    .threshold_ready (threshold_ready),
    .threshold       (threshold)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: check each transfer, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) tally.check_report(result);
    result_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  function automatic bbd_pkg::pixel_pair_t make_pair(input pair_kind_t kind);
    bbd_pkg::pixel_pair_t        p;
    logic [63:0]                 raw;
    logic [bbd_pkg::CH_BITS-1:0] f [3];
    logic [bbd_pkg::CH_BITS-1:0] m [3];
    logic [bbd_pkg::CH_BITS-1:0] corner_vals [10];
    int                          c;
    int                          b;
    raw = {$urandom, $urandom};
    p = raw[$bits(bbd_pkg::pixel_pair_t)-1:0];
    p.front_present = ($urandom_range(9) != 0);
    p.mask_present  = ($urandom_range(9) != 0);
    p.last_pixel    = 1'b0;
    f[0] = p.front_red;
    f[1] = p.front_green;
    f[2] = p.front_blue;
    m[0] = p.mask_red;
    m[1] = p.mask_green;
    m[2] = p.mask_blue;
    corner_vals = '{8'h00, 8'h07, 8'h08, 8'h0F, 8'h10, 8'hEF, 8'hF0, 8'hF7, 8'hF8, 8'hFF};
    case (kind)
      // near-white mask over near-black front, either side possibly absent
      PK_SKIP_BW: begin
        for (c = 0; c < 3; c++) begin
          f[c] = bbd_pkg::CH_BITS'($urandom_range(15, 0));
          m[c] = bbd_pkg::CH_BITS'($urandom_range(255, 240));
        end
      end
      // front covers mask in the top five bits
      PK_COVERED: begin
        p.front_present = 1'b1;
        p.mask_present  = 1'b1;
        for (c = 0; c < 3; c++) f[c] = m[c] | bbd_pkg::CH_BITS'($urandom);
      end
      // covered except for one top bit of one channel
      PK_ONE_BIT: begin
        p.front_present = 1'b1;
        p.mask_present  = 1'b1;
        for (c = 0; c < 3; c++) f[c] = m[c] | bbd_pkg::CH_BITS'($urandom);
        c = $urandom_range(2, 0);
        b = $urandom_range(7, bbd_pkg::RESID_SHIFT);
        m[c][b] = 1'b1;
        f[c][b] = 1'b0;
      end
      // large residue on every channel, mask just short of white
      PK_DENSE: begin
        p.mask_present = 1'b1;
        for (c = 0; c < 3; c++) f[c] = bbd_pkg::CH_BITS'($urandom_range(7, 0));
        m[0] = bbd_pkg::CH_BITS'($urandom_range(8'hEF, 8'hE0));
        m[1] = bbd_pkg::CH_BITS'($urandom_range(8'hFF, 8'hF8));
        m[2] = bbd_pkg::CH_BITS'($urandom_range(8'hFF, 8'hF8));
      end
      // values at the white, black and top-bit thresholds
      PK_CORNER: begin
        for (c = 0; c < 3; c++) begin
          f[c] = corner_vals[$urandom_range(9, 0)];
          m[c] = corner_vals[$urandom_range(9, 0)];
        end
      end
      default: ;
    endcase
    p.front_red   = f[0];
    p.front_green = f[1];
    p.front_blue  = f[2];
    p.mask_red    = m[0];
    p.mask_green  = m[1];
    p.mask_blue   = m[2];
    return p;
  endfunction

  function automatic bbd_pkg::pixel_pair_t pair_of(
    input logic [7:0] fr, input logic [7:0] fg, input logic [7:0] fb, input logic fp,
    input logic [7:0] mr, input logic [7:0] mg, input logic [7:0] mb, input logic mp,
    input logic last);
    bbd_pkg::pixel_pair_t p;
    p = '{fr, fg, fb, fp, mr, mg, mb, mp, last};
    return p;
  endfunction

  // One pixel transfer, with random idle cycles ahead of it
  task automatic send_pair(input bbd_pkg::pixel_pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel       <= p;
    pixel_valid <= 1'b1;
    do @(posedge clk); while (pixel_stall);
    tally.take_pair(p);
  endtask

  task automatic send_image(input int len, input bit heavy);
    bbd_pkg::pixel_pair_t p;
    pair_kind_t           kind;
    for (int i = 0; i < len; i++) begin
      kind = heavy ? PK_DENSE : pair_kind_t'($urandom_range(int'(PK_CORNER), 0));
      p = make_pair(kind);
      p.last_pixel = (i == len - 1);
      send_pair(p);
    end
  endtask

  // Hold off input until every report is in and the pipeline has emptied
  task automatic settle_block();
    pixel_valid <= 1'b0;
    while (tally.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [bbd_pkg::THR_BITS-1:0] value);
    threshold       <= value;
    threshold_valid <= 1'b1;
    do @(posedge clk); while (!threshold_ready);
    threshold_valid <= 1'b0;
    tally.set_threshold(value);
    thr_writes++;
  endtask

  // One random phase: new threshold and idle mix, then whole images
  task automatic run_phase(input int sidle, input int rstall,
                           input logic [bbd_pkg::THR_BITS-1:0] thr, input int n_pairs);
    int sent;
    int pick;
    int len;
    settle_block();
    send_idle_pct = sidle;
    stall_pct     = rstall;
    write_threshold(thr);
    sent = 0;
    while (sent < n_pairs) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        // long dense image, sum lands around the reset threshold
        len = $urandom_range(130, 100);
        send_image(len, 1'b1);
      end else if (pick < 16) begin
        len = $urandom_range(50, 15);
        send_image(len, 1'b0);
      end else begin
        len = $urandom_range(8, 1);
        send_image(len, 1'b0);
      end
      sent += len;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed image under the reset threshold: skip rules and absent pixels
    send_pair(pair_of(8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0));
    send_pair(pair_of(8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
    send_pair(pair_of(8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0));
    send_pair(pair_of(8'hFF, 8'hFF, 8'hFF, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
    send_pair(pair_of(8'h0F, 8'h0F, 8'h0F, 1'b1, 8'hEF, 8'hFF, 8'hFF, 1'b1, 1'b0));
    send_pair(pair_of(8'h10, 8'h00, 8'h00, 1'b1, 8'hF0, 8'hF0, 8'hF0, 1'b1, 1'b0));
    send_pair(pair_of(8'h0F, 8'h0F, 8'h0F, 1'b1, 8'hF0, 8'hF0, 8'hF0, 1'b1, 1'b0));
    send_pair(pair_of(8'h00, 8'h00, 8'h00, 1'b1, 8'h07, 8'h07, 8'h07, 1'b1, 1'b0));
    send_pair(pair_of(8'h00, 8'h00, 8'h00, 1'b1, 8'h08, 8'h00, 8'h00, 1'b1, 1'b0));
    send_pair(pair_of(8'h07, 8'h07, 8'h07, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0));
    send_pair(pair_of(8'h80, 8'h40, 8'h20, 1'b1, 8'h80, 8'h40, 8'h20, 1'b1, 1'b0));
    send_pair(pair_of(8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));

    // Threshold equal to the sum, then one above it
    settle_block();
    write_threshold(bbd_pkg::THR_BITS'(89));
    send_pair(pair_of(8'h0F, 8'h0F, 8'h0F, 1'b1, 8'hEF, 8'hFF, 8'hFF, 1'b1, 1'b0));
    send_pair(pair_of(8'h00, 8'h00, 8'h00, 1'b1, 8'h08, 8'h00, 8'h00, 1'b1, 1'b1));
    settle_block();
    write_threshold(bbd_pkg::THR_BITS'(90));
    send_pair(pair_of(8'h0F, 8'h0F, 8'h0F, 1'b1, 8'hEF, 8'hFF, 8'hFF, 1'b1, 1'b0));
    send_pair(pair_of(8'h00, 8'h00, 8'h00, 1'b1, 8'h08, 8'h00, 8'h00, 1'b1, 1'b1));

    // Threshold extremes with one-pixel images
    settle_block();
    write_threshold('0);
    send_pair(pair_of(8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1));
    settle_block();
    write_threshold({bbd_pkg::THR_BITS{1'b1}});
    send_pair(pair_of(8'h10, 8'h00, 8'h00, 1'b1, 8'hF0, 8'hF0, 8'hF0, 1'b1, 1'b1));

    // Random phases: sender idle %, result stall %, threshold, pairs
    run_phase(0,  0,  bbd_pkg::THR_RESET,                                  70);
    run_phase(81, 0,  '0,                                                  70);
    run_phase(0,  81, {bbd_pkg::THR_BITS{1'b1}},                           70);
    run_phase(12, 12, bbd_pkg::THR_BITS'($urandom_range(2000, 200)),       70);
    run_phase(81, 0,  bbd_pkg::THR_RESET,                                  70);
    run_phase(0,  81, bbd_pkg::THR_BITS'($urandom_range(600, 0)),          70);
    run_phase(12, 12, bbd_pkg::THR_BITS'($urandom),                        70);
    run_phase(0,  0,  bbd_pkg::THR_BITS'($urandom_range(11000, 9000)),     70);

    settle_block();
    $display("Sent %0d pixel pairs (%0d blended) under %0d threshold settings;",
             tally.pairs_taken, tally.pairs_blended, thr_writes);
    $display("checked %0d image reports, %0d of them with a mask required.",
             tally.reports_seen, tally.required_seen);
    if (tally.mismatches == 0 && tally.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
